### src/smaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smaf_pkg;

    localparam int MAX_WINDOW_DEF  = 256;
    localparam int MAX_FRAME_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int FEAT_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_KIND      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_LEN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_AC_MODE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ABS_PRE   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ABS_POST  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_USE_RATE  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE      = 3'd7;

    // Feature kinds.
    localparam logic [2:0] KIND_P2P_LAST = 3'd2;
    localparam logic [2:0] KIND_ABS_AREA = 3'd5;
    localparam logic [2:0] KIND_UNUSED   = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] sample;
        logic                              frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [FEAT_BITS-1:0] feature_value;
        logic                        status;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } cfg_item_t;

endpackage
`default_nettype wire

### src/smaf_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module smaf_divider #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] numer,
    input  wire logic [DEN_BITS-1:0] denom,
    output logic                     busy,
    output logic                     done,
    output logic [NUM_BITS-1:0]      quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quot_reg, quot_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next, done_reg, done_next;
    logic [DEN_BITS:0]   trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_BITS-1:0], quot_reg[NUM_BITS-1]};
        if (start) begin
            quot_next = numer;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) begin
            den_reg <= denom;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

### src/symmetric_moving_average_features.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Ports                          | Content
// input     | s_valid, s_ready, s_data       | sample, frame_start
// result    | m_valid, m_ready, m_data       | feature_value, status
// config    | cfg_valid, cfg_ready, cfg_data | register index, write data
//
// An accepted sample in a frame passes through the read, value and update states (memory read
// of the oldest and mid sample, window value, min/max and area update) before the next is taken.
// A frame end adds a state that starts the divide, a serial divide of 80 quotient bits
// and a result state; a status result without a divide skips only the divide.
// Reset is synchronous; the delay line needs no clearing pass since entries are only
// read once the count shows they were written in this frame.
// Input stalls while an item, a divide or a result is in flight; the result cycle waits while the
// previous result has not been taken.
module symmetric_moving_average_features #(
    parameter int MAX_WINDOW  = smaf_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire smaf_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output smaf_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire smaf_pkg::cfg_item_t cfg_data
);
    import smaf_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int AW      = $clog2(MAX_WINDOW);
    localparam int HMAX    = (MAX_WINDOW - 2) / 2;
    localparam int CB      = 13 + 1;                 // frame count, above the length register
    localparam int SB      = SAMPLE_BITS + AW + 2;   // window sum
    localparam int VB      = SB + AW + 2;            // window value
    localparam int AB      = VB + 13 + 1;            // area
    localparam int NB      = 64 + 16;
    localparam int DB      = 16 + AW + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_VAL  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    // Configuration registers.
    logic [2:0]  kind_reg;
    logic [6:0]  half_reg;
    logic [12:0] flen_reg;
    logic        ac_reg, absp_reg, absa_reg, user_reg;
    logic [15:0] rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= 3'd0;
            half_reg <= 7'd1;
            flen_reg <= 13'd128;
            ac_reg   <= 1'b0;
            absp_reg <= 1'b0;
            absa_reg <= 1'b0;
            user_reg <= 1'b0;
            rate_reg <= 16'd100;
        end else if (cfg_valid) begin
            case (cfg_data.index)
                REG_KIND:      kind_reg <= cfg_data.data[2:0];
                REG_HALF:      half_reg <= cfg_data.data[6:0];
                REG_FRAME_LEN: flen_reg <= cfg_data.data[12:0];
                REG_AC_MODE:   ac_reg   <= cfg_data.data[0];
                REG_ABS_PRE:   absp_reg <= cfg_data.data[0];
                REG_ABS_POST:  absa_reg <= cfg_data.data[0];
                REG_USE_RATE:  user_reg <= cfg_data.data[0];
                REG_RATE:      rate_reg <= cfg_data.data;
                default: ;
            endcase
        end
    end

    // Effective window from the live registers.
    logic [AW-1:0] h_eff;
    logic [AW:0]   w_eff;
    logic [12:0]   len_eff;
    assign h_eff   = (32'(half_reg) > HMAX) ? AW'(HMAX) : AW'(half_reg);
    assign w_eff   = {h_eff, 1'b1};
    assign len_eff = (flen_reg == 13'd0) ? 13'd1 : flen_reg;

    // Control and frame state.
    logic [2:0]           state_reg, state_next;
    logic                 active_reg;
    logic [AW-1:0]        wpos_reg;
    logic [CB-1:0]        cnt_reg;
    logic signed [SB-1:0] sum_reg;
    logic signed [VB-1:0] max_reg, min_reg, val_reg;
    logic signed [AB-1:0] area_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    out_item_t            out_reg;
    logic                 mval_reg;

    // Delay-line memory, two registered read ports.
    logic signed [SAMPLE_BITS-1:0] dl_mem [2**AW];
    logic signed [SAMPLE_BITS-1:0] old_q, mid_q;
    logic [AW-1:0] old_addr, mid_addr;

    logic s_fire;
    logic out_free;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !mval_reg || m_ready;
    assign old_addr = wpos_reg - w_eff[AW-1:0];
    assign mid_addr = wpos_reg - h_eff;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            dl_mem[wpos_reg] <= x_reg;
        end
        old_q <= dl_mem[old_addr];
        mid_q <= (h_eff == '0) ? x_reg : dl_mem[mid_addr];
    end

    // Window sum with the newest sample, minus the oldest once full.
    logic signed [SB-1:0] sum_new;
    logic signed [VB-1:0] val_new, val_abs;
    logic signed [VB+AW:0] mid_prod;
    assign sum_new = sum_reg + SB'(x_reg)
                   - ((cnt_reg > CB'(w_eff)) ? SB'(old_q) : SB'(0));
    assign mid_prod = $signed(mid_q) * $signed({1'b0, w_eff});
    assign val_new  = ac_reg ? VB'(mid_prod) - VB'(sum_new) : VB'(sum_new);
    assign val_abs  = (val_reg < 0) ? -val_reg : val_reg;

    // Frame-end divide.
    logic                  div_start, div_done, div_busy;
    logic [NB-1:0]         div_numer, div_quot;
    logic [DB-1:0]         div_denom;
    logic                  neg_reg;
    logic [15:0]           rate_eff;
    logic [AB-1:0]         area_mag;
    logic [VB-1:0]         span;
    assign rate_eff = !user_reg ? 16'd1 : ((rate_reg == 16'd0) ? 16'd1 : rate_reg);
    assign area_mag = (area_reg < 0) ? AB'(-area_reg) : AB'(area_reg);
    assign span     = VB'(max_reg - min_reg);
    assign div_numer = (kind_reg <= KIND_P2P_LAST) ? (NB'(span) << 16)
                                                    : (NB'(area_mag) << 16);
    assign div_denom = (kind_reg <= KIND_P2P_LAST) ? DB'(w_eff)
                                                    : DB'(w_eff) * DB'(rate_eff);

    smaf_divider #(.NUM_BITS(NB), .DEN_BITS(DB)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .numer  (div_numer),
        .denom  (div_denom),
        .busy   (div_busy),
        .done   (div_done),
        .quot   (div_quot)
    );

    // The divide starts in the cycle after the last update, from the final sums.
    logic frame_end;
    assign frame_end = cnt_reg >= CB'(len_eff);
    assign div_start = (state_reg == ST_FIN)
                     && (cnt_reg >= CB'(w_eff)) && (kind_reg != KIND_UNUSED);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire && (s_data.frame_start || active_reg)) state_next = ST_READ;
            ST_READ: state_next = ST_VAL;
            ST_VAL:  state_next = ST_UPD;
            ST_UPD: begin
                if (!frame_end) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (div_start) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:  if (div_done && !div_busy) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            wpos_reg   <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            max_reg    <= '0;
            min_reg    <= '0;
            area_reg   <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_OUT) && out_free) begin
                mval_reg <= 1'b1;
            end else if (m_ready) begin
                mval_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        x_reg <= s_data.sample;
                        if (s_data.frame_start) begin
                            active_reg <= 1'b1;
                            cnt_reg    <= CB'(1);
                            sum_reg    <= '0;
                            max_reg    <= '0;
                            min_reg    <= '0;
                            area_reg   <= '0;
                        end else if (active_reg) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_VAL: begin
                    sum_reg  <= sum_new;
                    val_reg  <= val_new;
                    wpos_reg <= wpos_reg + 1'b1;
                end
                ST_UPD: begin
                    if (cnt_reg >= CB'(w_eff)) begin
                        if (cnt_reg == CB'(w_eff)) begin
                            max_reg <= val_reg;
                            min_reg <= val_reg;
                        end else begin
                            if (val_reg > max_reg) max_reg <= val_reg;
                            if (val_reg < min_reg) min_reg <= val_reg;
                        end
                        area_reg <= area_reg + (absp_reg ? AB'(val_abs) : AB'(val_reg));
                    end
                    if (frame_end) begin
                        active_reg <= 1'b0;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        if ((cnt_reg < CB'(w_eff)) || (kind_reg == KIND_UNUSED)) begin
                            out_reg.feature_value <= '0;
                            out_reg.status        <= 1'b1;
                        end else if (kind_reg <= KIND_P2P_LAST || !neg_reg) begin
                            out_reg.feature_value <= FEAT_BITS'(div_quot);
                            out_reg.status        <= 1'b0;
                        end else begin
                            out_reg.feature_value <= -FEAT_BITS'(div_quot);
                            out_reg.status        <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Sign of the area result, fixed when the divide starts.
    always_ff @(posedge aclk) begin
        if (div_start) begin
            neg_reg <= (area_reg < 0) && !absa_reg && (kind_reg != KIND_ABS_AREA);
        end
    end

    assign m_valid = mval_reg;
    assign m_data  = out_reg;
endmodule
`default_nettype wire

### verif/symmetric_moving_average_features_test.sv
`timescale 1ns / 1ps
module symmetric_moving_average_features_test;
    import smaf_pkg::*;

    localparam logic [2:0] KIND_P2P_FIRST  = 3'd0;
    localparam logic [2:0] KIND_AREA_FIRST = 3'd3;
    localparam int DELAY_DEPTH   = 256;
    localparam int SETTLE_CYCLES = 100;

    // Expected-feature tracker: mirrors the block's frame arithmetic and
    // holds the features that are still to come out.
    class feature_scoreboard;
        logic [2:0]  kind;
        logic [6:0]  half;
        logic [12:0] flen;
        bit          ac, abs_pre, abs_post, use_rate;
        logic [15:0] rate;
        longint      delay_line[DELAY_DEPTH];
        int          wpos;
        longint      wsum, wmax, wmin, area;
        int          count;
        bit          open;
        out_item_t   feature_q[$];
        int          errors;
        int          checked;

        function new();
            foreach (delay_line[i]) delay_line[i] = 0;
            wpos = 0;
            clear_frame();
            open = 0;
            kind = KIND_P2P_FIRST;
            half = 7'd1;
            flen = 13'd128;
            ac = 0;
            abs_pre = 0;
            abs_post = 0;
            use_rate = 0;
            rate = 16'd100;
            errors = 0;
            checked = 0;
        endfunction

        function void clear_frame();
            wsum = 0;
            wmax = 0;
            wmin = 0;
            area = 0;
            count = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(cfg_item_t c);
            case (c.index)
                REG_KIND:      kind = c.data[2:0];
                REG_HALF:      half = c.data[6:0];
                REG_FRAME_LEN: flen = c.data[12:0];
                REG_AC_MODE:   ac = c.data[0];
                REG_ABS_PRE:   abs_pre = c.data[0];
                REG_ABS_POST:  abs_post = c.data[0];
                REG_USE_RATE:  use_rate = c.data[0];
                REG_RATE:      rate = c.data;
                default: ;
            endcase
        endfunction

        // Update the window state with one accepted sample; queue the feature at frame end.
        function void note_input(in_item_t it);
            longint x, mid, v;
            int h, w, len;
            longint unsigned span, q, rate_div, mag;
            bit neg;
            out_item_t e;
            x = it.sample;
            if (it.frame_start) begin
                clear_frame();
                open = 1;
            end
            if (!open) return;
            h = half;
            w = 2 * h + 1;
            len = (flen == 0) ? 1 : flen;
            delay_line[wpos] = x;
            count++;
            wsum += x;
            if (count > w) wsum -= delay_line[(wpos + DELAY_DEPTH - w) % DELAY_DEPTH];
            if (count >= w) begin
                mid = delay_line[(wpos + DELAY_DEPTH - h) % DELAY_DEPTH];
                v = ac ? mid * w - wsum : wsum;
                if (count == w) begin
                    wmax = v;
                    wmin = v;
                end else begin
                    if (v > wmax) wmax = v;
                    if (v < wmin) wmin = v;
                end
                area += (abs_pre && v < 0) ? -v : v;
            end
            wpos = (wpos + 1) % DELAY_DEPTH;
            if (count < len) return;

            // Frame end: form the feature.
            open = 0;
            e.feature_value = '0;
            e.status = 1'b0;
            if (count < w || kind == KIND_UNUSED) begin
                e.status = 1'b1;
            end else if (kind <= KIND_P2P_LAST) begin
                span = wmax - wmin;
                e.feature_value = (span << 16) / w;
            end else begin
                rate_div = use_rate ? ((rate == 0) ? 1 : rate) : 1;
                mag = (area < 0) ? -area : area;
                q = (mag << 16) / (w * rate_div);
                neg = (area < 0) && !(abs_post || kind == KIND_ABS_AREA);
                e.feature_value = neg ? -q : q;
            end
            feature_q.push_back(e);
        endfunction

        task check(out_item_t got);
            out_item_t e;
            if (feature_q.size() == 0) begin
                report($sformatf("unexpected feature %0d status %0d",
                                 got.feature_value, got.status));
                return;
            end
            e = feature_q.pop_front();
            checked++;
            if (got.feature_value !== e.feature_value)
                report($sformatf("feature_value got %0d want %0d",
                                 got.feature_value, e.feature_value));
            if (got.status !== e.status)
                report($sformatf("status got %0d want %0d", got.status, e.status));
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_item_t cfg_data;

    int send_idle_pct;
    int recv_idle_pct;
    int sample_total;
    int setting_total;

    feature_scoreboard sb = new();

    symmetric_moving_average_features u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with a 4 ns period.
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Observe every transaction on the three channels.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_data);
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check(m_data);
        end
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("Timeout waiting for the block");
        $display("Some tests failed");
        $finish;
    end

    // Leaves s_valid high; callers that pause lower it first.
    task automatic send_sample(input logic signed [15:0] smp, input bit fs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{sample: smp, frame_start: fs};
        sample_total++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off input until every expected feature has arrived.
    task automatic drain_features();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.feature_q.size() != 0);
    endtask

    task automatic settle();
        drain_features();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= '{index: idx, data: value};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Write every register; spare data bits get random junk.
    task automatic apply_setting(input logic [2:0] kind, input int h, input int len,
                                 input bit ac, input bit pre, input bit post,
                                 input bit use_rate, input logic [15:0] rate);
        settle();
        write_reg(REG_KIND, {13'($urandom_range(8191)), kind});
        write_reg(REG_HALF, {9'($urandom_range(511)), h[6:0]});
        write_reg(REG_FRAME_LEN, {3'($urandom_range(7)), len[12:0]});
        write_reg(REG_AC_MODE, {15'($urandom_range(32767)), ac});
        write_reg(REG_ABS_PRE, {15'($urandom_range(32767)), pre});
        write_reg(REG_ABS_POST, {15'($urandom_range(32767)), post});
        write_reg(REG_USE_RATE, {15'($urandom_range(32767)), use_rate});
        write_reg(REG_RATE, rate);
        setting_total++;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            2: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // One frame; noise adds restarts mid-frame and samples outside any frame.
    task automatic send_frame(input int len, input bit noisy, input bit live);
        for (int i = 0; i < len; i++) begin
            if (live && i == len / 2) begin
                settle();
                write_reg(REG_HALF, 16'($urandom_range(6)));
                write_reg(REG_AC_MODE, 16'($urandom_range(1)));
            end
            send_sample(pick_sample(), i == 0 || (noisy && $urandom_range(40) == 0));
        end
        if (noisy && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_sample(pick_sample(), 1'b0);
    endtask

    initial begin
        int h, w, len, phase_items;
        logic [2:0] kind;
        logic [15:0] rate;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        m_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sample_total = 0;
        setting_total = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: sample extremes with a one-sample window.
        apply_setting(KIND_AREA_FIRST, 0, 1, 0, 0, 0, 0, 16'd1);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(-16'sh8000, 1'b1);
        // A sample with no frame open is dropped.
        send_sample(16'sh1234, 1'b0);
        // Zero sample rate behaves as one.
        apply_setting(KIND_AREA_FIRST, 0, 1, 1, 1, 1, 1, 16'd0);
        send_sample(-16'sh8000, 1'b1);
        // Unused kind gives a status result.
        apply_setting(KIND_UNUSED, 0, 1, 0, 0, 0, 0, 16'd100);
        send_sample(16'sh0100, 1'b1);
        // Frame shorter than the window.
        apply_setting(KIND_P2P_FIRST, 2, 3, 0, 0, 0, 0, 16'd100);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(-16'sh8000, 1'b0);
        send_sample(16'sh0001, 1'b0);
        // Zero frame length acts as one.
        apply_setting(KIND_P2P_FIRST, 2, 0, 0, 0, 0, 0, 16'd100);
        send_sample(16'sh0005, 1'b1);
        // Restart in the middle of a frame, AC area with forced absolute value.
        apply_setting(KIND_ABS_AREA, 1, 6, 1, 0, 0, 1, 16'd65535);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(-16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? -16'sh8000 : 16'sh7FFF, i == 0);

        // Random phases over many register settings.
        for (int p = 0; p < 24; p++) begin
            send_idle_pct = (p < 8) ? 10 : (p < 16) ? 73 : 0;
            recv_idle_pct = (p < 8) ? 73 : (p < 16) ? 10 : 0;
            kind = (p < 8) ? p[2:0] : 3'($urandom_range(6));
            h = (p == 0) ? 0 : (p == 1) ? 127 : $urandom_range(12);
            w = 2 * h + 1;
            case ($urandom_range(7))
                0: len = $urandom_range(1, w);
                default: len = w + $urandom_range(16);
            endcase
            if (p == 2) len = 1;
            case ($urandom_range(3))
                0: rate = 16'd1;
                1: rate = 16'd65535;
                2: rate = 16'd0;
                default: rate = 16'($urandom);
            endcase
            apply_setting(kind, h, len, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), rate);
            phase_items = 0;
            while (phase_items < 28) begin
                if (p == 3 && phase_items > 0) drain_features();
                send_frame(len, $urandom_range(3) == 0, p == 10 && phase_items == 0);
                phase_items += len;
            end
        end

        // Wait out the last features and the block's own latency.
        drain_features();
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);
        if (sb.feature_q.size() != 0)
            sb.report($sformatf("%0d features never arrived", sb.feature_q.size()));
        $display("Sent %0d samples under %0d register settings; checked %0d features.",
                 sample_total, setting_total, sb.checked);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
